/* hw/rtl/tcpt_pkg.sv */
// Package for the three-channel programmable timer.
// Holds payload structs, command codes and widths; no dependencies.
package tcpt_pkg;

    localparam int unsigned NumTimers      = 3;
    localparam int unsigned PrescaleDivide = 8;
    localparam int unsigned PreW           = 3;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_CLK   = 3'd3,
        CMD_GATE  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] addr;
        logic [7:0] wdata;
        logic [1:0] timer_sel;
        logic       pin_level;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic [2:0] timer_out;
    } t_out;

    typedef struct packed {
        logic [2:0][7:0]  ctrl;
        logic [2:0][15:0] cnt;
        logic [2:0][15:0] lat;
        logic [2:0]       outl;
        logic [2:0]       fired;
        logic [2:0]       en;
        logic [2:0]       irqf;
        logic [2:0]       seen;
        logic [7:0]       lobuf;
        logic [7:0]       hibuf;
        logic [PreW-1:0]  pre;
        logic [2:0]       lclk;
        logic [2:0]       lgate;
    } t_state;

endpackage

/* hw/rtl/tcpt_core.sv */
// Next-state logic of the timer: one input transaction applied to the state.
// Depends on tcpt_pkg.
module tcpt_core (
    input  tcpt_pkg::t_state i_st,
    input  tcpt_pkg::t_in    i_item,
    output tcpt_pkg::t_state o_st,
    output logic [7:0]       o_rdata
);
    import tcpt_pkg::*;

    t_state s;
    logic [7:0] d;
    logic [1:0] t;
    logic [1:0] diffs;
    logic [2:0] m;

    function automatic t_state do_reload(t_state x, int k);
        logic [2:0] mm;
        mm = x.ctrl[k][5:3];
        x.cnt[k] = x.lat[k];
        x.fired[k] = 1'b0;
        if (mm == 3'd4 || mm == 3'd6) x.outl[k] = 1'b1;
        x.en[k] = 1'b1;
        return x;
    endfunction

    function automatic t_state do_count(t_state x, int k);
        logic [7:0] l, h;
        logic [2:0] mm;
        logic ex;
        l = x.cnt[k][7:0];
        h = x.cnt[k][15:8];
        mm = x.ctrl[k][5:3];
        ex = 1'b0;
        if (x.ctrl[k][2]) begin
            if (l != 8'd0) x.cnt[k] = {h, l - 8'd1};
            else if (h != 8'd0) x.cnt[k] = {h - 8'd1, x.lat[k][7:0]};
            else ex = 1'b1;
        end else begin
            if (x.cnt[k] != 16'd0) x.cnt[k] = x.cnt[k] - 16'd1;
            else ex = 1'b1;
        end
        if (ex) begin
            x.irqf[k] = 1'b1;
            x.seen[k] = 1'b0;
            if (x.ctrl[k][7]) begin
                if (mm == 3'd0 || mm == 3'd2) x.outl[k] = ~x.outl[k];
                if ((mm == 3'd4 || mm == 3'd6) && !x.fired[k]) begin
                    x.outl[k] = 1'b1;
                    x.fired[k] = 1'b1;
                end
            end
            x = do_reload(x, k);
        end
        return x;
    endfunction

    function automatic t_state do_tick(t_state x, int k);
        logic [PreW:0] n;
        if (x.en[k]) begin
            if (k == 2 && x.ctrl[2][0]) begin
                n = {1'b0, x.pre} + 1'b1;
                if (n >= (PreW+1)'(PrescaleDivide)) begin
                    x.pre = '0;
                    x = do_count(x, k);
                end else begin
                    x.pre = n[PreW-1:0];
                end
            end else begin
                x.pre = '0;
                x = do_count(x, k);
            end
        end
        return x;
    endfunction

    always_comb begin
        s = i_st;
        o_rdata = 8'd0;
        d = i_item.wdata;
        t = 2'd0;
        diffs = 2'd0;
        m = 3'd0;
        unique case (i_item.cmd)
            CMD_WRITE: begin
                if (i_item.addr <= 3'd1) begin
                    t = (i_item.addr == 3'd1) ? 2'd1 : (s.ctrl[1][0] ? 2'd0 : 2'd2);
                    diffs = d[1:0] ^ s.ctrl[t][1:0];
                    s.ctrl[t] = d;
                    if (t == 2'd0 && diffs[0]) begin
                        if (d[0]) s.en = 3'b000;
                        else for (int k = 0; k < 3; k++) s = do_reload(s, k);
                        s.irqf = 3'b000;
                        if (diffs[1]) s = do_reload(s, 0);
                    end
                end else if (!i_item.addr[0]) begin
                    s.hibuf = d;
                end else begin
                    t = 2'(i_item.addr[2:1] - 2'd1);
                    s.lat[t] = {s.hibuf, d};
                    s.irqf[t] = 1'b0;
                    if (!s.ctrl[t][4]) s = do_reload(s, int'(t));
                end
            end
            CMD_READ: begin
                if (i_item.addr == 3'd1) begin
                    s.seen = s.seen | s.irqf;
                    o_rdata = {|(i_st.irqf & {i_st.ctrl[2][6], i_st.ctrl[1][6],
                               i_st.ctrl[0][6]}), 4'd0, i_st.irqf};
                end else if (i_item.addr != 3'd0 && !i_item.addr[0]) begin
                    t = 2'(i_item.addr[2:1] - 2'd1);
                    if (s.seen[t]) s.irqf[t] = 1'b0;
                    s.lobuf = s.cnt[t][7:0];
                    o_rdata = s.cnt[t][15:8];
                end else if (i_item.addr != 3'd0) begin
                    o_rdata = s.lobuf;
                end
            end
            CMD_TICK: begin
                for (int k = 0; k < 3; k++)
                    if (s.ctrl[k][1]) s = do_tick(s, k);
            end
            CMD_CLK: begin
                if (i_item.timer_sel != 2'd3) begin
                    t = i_item.timer_sel;
                    if (!s.ctrl[t][1] && i_item.pin_level && !s.lclk[t])
                        s = do_tick(s, int'(t));
                    s.lclk[t] = i_item.pin_level;
                end
            end
            CMD_GATE: begin
                if (i_item.timer_sel != 2'd3) begin
                    t = i_item.timer_sel;
                    m = s.ctrl[t][5:3];
                    if (!m[0] && !i_item.pin_level && s.lgate[t])
                        s = do_reload(s, int'(t));
                    s.lgate[t] = i_item.pin_level;
                end
            end
            default: ;
        endcase
        o_st = s;
    end

endmodule

/* hw/rtl/three_channel_programmable_timer.sv */
// Top level: timer state register and result register.
// Depends on tcpt_pkg and tcpt_core.
// Output: the result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while i_ready does not hold the output; the state update is a single pass.
// Reset: synchronous active low; control zero = 1, counters and latches 0xFFFF.
module three_channel_programmable_timer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tcpt_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output tcpt_pkg::t_out  o_data
);
    import tcpt_pkg::*;

    localparam t_state StReset = '{
        ctrl: {8'd0, 8'd0, 8'd1}, cnt: {3{16'hFFFF}}, lat: {3{16'hFFFF}},
        outl: 3'b000, fired: 3'b000, en: 3'b000, irqf: 3'b000, seen: 3'b000,
        lobuf: 8'd0, hibuf: 8'd0, pre: {PreW{1'b0}}, lclk: 3'b000, lgate: 3'b000};

    t_state r_st, n_st;
    logic [7:0] rd;
    t_out n_out;
    logic acc;

    tcpt_core u_core (.i_st(r_st), .i_item(i_data), .o_st(n_st), .o_rdata(rd));

    assign o_ready = !o_valid || i_ready;
    assign acc = i_valid && o_ready;

    always_comb begin
        n_out.rdata = rd;
        n_out.irq = |(n_st.irqf & {n_st.ctrl[2][6], n_st.ctrl[1][6], n_st.ctrl[0][6]});
        n_out.timer_out = n_st.outl & {n_st.ctrl[2][7], n_st.ctrl[1][7], n_st.ctrl[0][7]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StReset;
            o_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_st <= n_st;
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) o_data <= n_out;
    end

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_data.cmd != CMD_READ |=> o_data.rdata == 8'd0)
        else $error("nonzero read data on non-read");
    a_out_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.timer_out & ~{r_st.ctrl[2][7], r_st.ctrl[1][7],
                      r_st.ctrl[0][7]}) == 3'b000))
        else $error("timer output without enable");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_st))
        else $error("state moved without transaction");

endmodule
